// ===== src/ccse_pkg.sv =====
// Shared types, register map, mode codes and CRC step functions
// for the crc8/crc16 stream engine. No dependencies.
package ccse_pkg;

  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned RegIdxW  = 3;

  localparam logic [RegIdxW-1:0] REG_MODE   = 3'd0;
  localparam logic [RegIdxW-1:0] REG_POLY8  = 3'd1;
  localparam logic [RegIdxW-1:0] REG_INIT8  = 3'd2;
  localparam logic [RegIdxW-1:0] REG_POLY16 = 3'd3;
  localparam logic [RegIdxW-1:0] REG_INIT16 = 3'd4;

  localparam logic [1:0] MODE_CRC8   = 2'd0;
  localparam logic [1:0] MODE_XMODEM = 2'd1;
  localparam logic [1:0] MODE_KERMIT = 2'd2;
  localparam logic [1:0] MODE_ZERO   = 2'd3;

  localparam logic [7:0]  POLY8_RST  = 8'h07;
  localparam logic [7:0]  INIT8_RST  = 8'h00;
  localparam logic [15:0] POLY16_RST = 16'h1021;
  localparam logic [15:0] INIT16_RST = 16'h0000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  poly8;
    logic [7:0]  init8;
    logic [15:0] poly16;
    logic [15:0] init16;
    logic [15:0] init16_odd;
  } cfg_t;

  typedef struct packed {
    logic s1_valid;
    logic s1_last;
    logic s1_fire;
  } core_stat_t;

  function automatic logic [7:0] feed8(input logic [7:0] r, input logic [7:0] b,
                                       input logic [7:0] poly);
    logic [7:0] v;
    v = r ^ b;
    for (int i = 0; i < 8; i++) begin
      v = v[7] ? ({v[6:0], 1'b0} ^ poly) : {v[6:0], 1'b0};
    end
    return v;
  endfunction

  function automatic logic [15:0] feed16(input logic [15:0] r, input logic [7:0] b,
                                         input logic [15:0] poly);
    logic [15:0] v;
    v = r ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      v = v[15] ? ({v[14:0], 1'b0} ^ poly) : {v[14:0], 1'b0};
    end
    return v;
  endfunction

  function automatic logic [7:0] flip8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[i];
    end
    return r;
  endfunction

  function automatic logic [15:0] flip16(input logic [15:0] v);
    logic [15:0] r;
    for (int i = 0; i < 16; i++) begin
      r[15-i] = v[i];
    end
    return r;
  endfunction

endpackage

// ===== src/ccse_if.sv =====
// Valid/ready channel interfaces for message bytes and finished CRC values.
// No dependencies.
interface ccse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first;
  logic       last;
  logic       odd_length;

  modport source (output valid, output data_byte, output first, output last,
                  output odd_length, input ready);
  modport sink (input valid, input data_byte, input first, input last,
                input odd_length, output ready);
endinterface

interface ccse_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] crc_value;

  modport source (output valid, output crc_value, input ready);
  modport sink (input valid, input crc_value, output ready);
endinterface

// ===== src/ccse_cfg.sv =====
// APB configuration registers and the precomputed odd-length start value.
// Depends on ccse_pkg.
module ccse_cfg import ccse_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  logic [1:0]         mode_q;
  logic [7:0]         poly8_q;
  logic [7:0]         init8_q;
  logic [15:0]        poly16_q;
  logic [15:0]        init16_q;
  logic [15:0]        init16_odd_q;
  logic [RegIdxW-1:0] idx;
  logic               wr_en;

  assign idx    = paddr[ApbAddrW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_CRC8;
      poly8_q  <= POLY8_RST;
      init8_q  <= INIT8_RST;
      poly16_q <= POLY16_RST;
      init16_q <= INIT16_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_MODE:   mode_q   <= pwdata[1:0];
        REG_POLY8:  poly8_q  <= pwdata[7:0];
        REG_INIT8:  init8_q  <= pwdata[7:0];
        REG_POLY16: poly16_q <= pwdata[15:0];
        REG_INIT16: init16_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // start value with a leading zero byte already stepped in
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init16_odd_q <= feed16(INIT16_RST, 8'h00, POLY16_RST);
    end else begin
      init16_odd_q <= feed16(init16_q, 8'h00, poly16_q);
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE:   prdata = {{(ApbDataW-2){1'b0}}, mode_q};
      REG_POLY8:  prdata = {{(ApbDataW-8){1'b0}}, poly8_q};
      REG_INIT8:  prdata = {{(ApbDataW-8){1'b0}}, init8_q};
      REG_POLY16: prdata = {{(ApbDataW-16){1'b0}}, poly16_q};
      REG_INIT16: prdata = {{(ApbDataW-16){1'b0}}, init16_q};
      default:    prdata = '0;
    endcase
  end

  assign cfg_o.mode       = mode_q;
  assign cfg_o.poly8      = poly8_q;
  assign cfg_o.init8      = init8_q;
  assign cfg_o.poly16     = poly16_q;
  assign cfg_o.init16     = init16_q;
  assign cfg_o.init16_odd = init16_odd_q;

endmodule

// ===== src/ccse_step.sv =====
// One-byte CRC update: next register value and finished result per mode.
// Depends on ccse_pkg.
module ccse_step import ccse_pkg::*; (
  input  cfg_t        cfg_i,
  input  logic [15:0] crc_i,
  input  logic [7:0]  data_byte_i,
  input  logic        first_i,
  input  logic        odd_length_i,
  output logic [15:0] crc_next_o,
  output logic [15:0] result_o
);

  logic [15:0] base16;
  logic [7:0]  base8;
  logic [7:0]  byte16;
  logic [15:0] next16;
  logic [7:0]  next8;

  always_comb begin
    base8  = first_i ? cfg_i.init8 : crc_i[7:0];
    next8  = feed8(base8, data_byte_i, cfg_i.poly8);
    base16 = first_i ? (odd_length_i ? cfg_i.init16_odd : cfg_i.init16) : crc_i;
    byte16 = (cfg_i.mode == MODE_KERMIT) ? flip8(data_byte_i) : data_byte_i;
    next16 = feed16(base16, byte16, cfg_i.poly16);
    case (cfg_i.mode) inside
      MODE_CRC8: begin
        crc_next_o = {8'h00, next8};
        result_o   = {8'h00, next8};
      end
      MODE_XMODEM, MODE_KERMIT: begin
        crc_next_o = next16;
        result_o   = (cfg_i.mode == MODE_KERMIT) ? flip16(next16) : next16;
      end
      default: begin
        crc_next_o = first_i ? 16'h0000 : crc_i;
        result_o   = 16'h0000;
      end
    endcase
  end

endmodule

// ===== src/ccse_core.sv =====
// Input register, CRC state register and result register around ccse_step.
// Depends on ccse_pkg, ccse_if and ccse_step.
module ccse_core import ccse_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  ccse_in_if.sink     in_item,
  ccse_out_if.source  out_item,
  output core_stat_t  stat_o
);

  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        s1_first_q;
  logic        s1_last_q;
  logic        s1_odd_q;
  logic [15:0] crc_q;
  logic [15:0] crc_d;
  logic [15:0] res_d;
  logic        out_valid_q;
  logic [15:0] out_crc_q;
  logic        res_free;
  logic        s1_fire;
  logic        in_fire;

  assign res_free      = !out_valid_q || out_item.ready;
  assign s1_fire       = s1_valid_q && (!s1_last_q || res_free);
  assign in_item.ready = !s1_valid_q || s1_fire;
  assign in_fire       = in_item.valid && in_item.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_item.ready) begin
      s1_valid_q <= in_item.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q  <= in_item.data_byte;
      s1_first_q <= in_item.first;
      s1_last_q  <= in_item.last;
      s1_odd_q   <= in_item.odd_length;
    end
  end

  ccse_step u_step (
    .cfg_i        (cfg_i),
    .crc_i        (crc_q),
    .data_byte_i  (s1_byte_q),
    .first_i      (s1_first_q),
    .odd_length_i (s1_odd_q),
    .crc_next_o   (crc_d),
    .result_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= 16'h0000;
    end else if (s1_fire) begin
      crc_q <= crc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_free) begin
      out_valid_q <= s1_fire && s1_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_last_q) begin
      out_crc_q <= res_d;
    end
  end

  assign out_item.valid     = out_valid_q;
  assign out_item.crc_value = out_crc_q;

  assign stat_o.s1_valid = s1_valid_q;
  assign stat_o.s1_last  = s1_last_q;
  assign stat_o.s1_fire  = s1_fire;

endmodule

// ===== src/crc8_crc16_stream_engine_unit.sv =====
// A last item passes the input register, then the result register; a stall delays it.
// Throughput: one item per cycle; the CRC register update is a single 8-step shift.
// A waiting result blocks only a following last item; other items keep flowing.
// Reset (rst_ni low, asynchronous): CRC register zero, registers at defaults,
// channels empty. Depends on ccse_pkg, ccse_if, ccse_cfg and ccse_core.
module crc8_crc16_stream_engine_unit import ccse_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  ccse_in_if.sink             in_item,
  ccse_out_if.source          out_item
);

  cfg_t       cfg;
  core_stat_t stat;

  ccse_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ccse_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .in_item  (in_item),
    .out_item (out_item),
    .stat_o   (stat)
  );

  // a result appears only after a last item left the input register
  a_res_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_item.valid) |-> $past(stat.s1_fire && stat.s1_last))
    else $error("result without a last item");

  // a last item leaving the input register always shows up as a result
  a_last_gives_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.s1_fire && stat.s1_last) |=> out_item.valid)
    else $error("last item lost");

  // input backpressure only from a last item held behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_item.ready |-> (stat.s1_valid && stat.s1_last && out_item.valid && !out_item.ready))
    else $error("unexpected input stall");

endmodule

// ===== verif/ccse_crc_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the crc8/crc16 stream engine: mirrors APB register writes, predicts
// the crc of every framed message from the accepted bytes and checks the result channel.
// Depends on ccse_pkg and ccse_if.
module ccse_crc_checker import ccse_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  ccse_in_if                  in_item,
  ccse_out_if                 out_item,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  item_count_o,
  output int                  crc_count_o
);

  logic [1:0]  mode_q;
  logic [7:0]  poly8_q;
  logic [7:0]  init8_q;
  logic [15:0] poly16_q;
  logic [15:0] init16_q;
  logic [15:0] crc_state;
  logic [15:0] crc_due [$];
  int          fails;
  int          items;
  int          crcs;

  function automatic logic [7:0] lfsr8(input logic [7:0] a, input logic [7:0] g);
    logic [7:0] v;
    v = a;
    repeat (8) v = {v[6:0], 1'b0} ^ (v[7] ? g : 8'h00);
    return v;
  endfunction

  function automatic logic [15:0] lfsr16(input logic [15:0] a, input logic [15:0] g);
    logic [15:0] v;
    v = a;
    repeat (8) v = {v[14:0], 1'b0} ^ (v[15] ? g : 16'h0000);
    return v;
  endfunction

  // updates crc_state for one byte and returns the crc as it would be emitted
  function automatic logic [15:0] advance_crc(input logic [7:0] b, input logic f,
                                              input logic odd);
    logic [7:0]  d;
    logic [15:0] r;
    d = b;
    r = '0;
    case (mode_q)
      MODE_CRC8: begin
        if (f) crc_state = {8'h00, init8_q};
        crc_state = {8'h00, lfsr8(crc_state[7:0] ^ b, poly8_q)};
        r = crc_state;
      end
      MODE_XMODEM, MODE_KERMIT: begin
        if (mode_q == MODE_KERMIT) d = {<<{b}};
        if (f) crc_state = odd ? lfsr16(init16_q, poly16_q) : init16_q;
        crc_state = lfsr16(crc_state ^ {d, 8'h00}, poly16_q);
        r = crc_state;
        if (mode_q == MODE_KERMIT) r = {<<{crc_state}};
      end
      default: begin
        if (f) crc_state = '0;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [15:0] want;
    logic [15:0] pred;
    if (!rst_ni) begin
      mode_q    = MODE_CRC8;
      poly8_q   = POLY8_RST;
      init8_q   = INIT8_RST;
      poly16_q  = POLY16_RST;
      init16_q  = INIT16_RST;
      crc_state = '0;
      crc_due.delete();
      fails     = 0;
      items     = 0;
      crcs      = 0;
    end else begin
      if (out_item.valid && out_item.ready) begin
        if (crc_due.size() == 0) begin
          $display("%0t: crc %04h arrived with nothing expected", $time, out_item.crc_value);
          fails++;
        end else begin
          want = crc_due.pop_front();
          crcs++;
          if (out_item.crc_value !== want) begin
            $display("%0t: crc mismatch, expected %04h, actual %04h", $time, want,
                     out_item.crc_value);
            fails++;
          end
        end
      end
      if (in_item.valid && in_item.ready) begin
        items++;
        pred = advance_crc(in_item.data_byte, in_item.first, in_item.odd_length);
        if (in_item.last) crc_due = {crc_due, pred};
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[ApbAddrW-1:2])
          REG_MODE:   mode_q   = pwdata[1:0];
          REG_POLY8:  poly8_q  = pwdata[7:0];
          REG_INIT8:  init8_q  = pwdata[7:0];
          REG_POLY16: poly16_q = pwdata[15:0];
          REG_INIT16: init16_q = pwdata[15:0];
          default: ;
        endcase
      end
    end
    fail_count_o <= fails;
    pending_o    <= crc_due.size();
    item_count_o <= items;
    crc_count_o  <= crcs;
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Top of the crc8/crc16 stream engine testbench: clock, reset, APB register setup,
// framed byte stimulus with idle and stall phases, and the verdict.
// Depends on ccse_pkg, ccse_if, ccse_crc_checker and crc8_crc16_stream_engine_unit.
module tb import ccse_pkg::*; ();

  localparam int NumPhases     = 12;
  localparam int ItemsPerPhase = 85;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  int                  fail_count;
  int                  pending;
  int                  item_count;
  int                  crc_count;
  int                  send_pct  = 0;
  int                  stall_pct = 0;

  ccse_in_if  in_item ();
  ccse_out_if out_item ();

  crc8_crc16_stream_engine_unit uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_item  (in_item),
    .out_item (out_item)
  );

  ccse_crc_checker crc_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .in_item      (in_item),
    .out_item     (out_item),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .item_count_o (item_count),
    .crc_count_o  (crc_count)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_item.ready <= rst_ni && ($urandom_range(99) >= stall_pct);
  end

  task automatic push_byte(input logic [7:0] b, input logic f, input logic l,
                           input logic odd);
    while ($urandom_range(99) < send_pct) begin
      in_item.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_item.valid      <= 1'b1;
    in_item.data_byte  <= b;
    in_item.first      <= f;
    in_item.last       <= l;
    in_item.odd_length <= odd;
    do @(posedge clk_i); while (!in_item.ready);
  endtask

  task automatic drain_engine();
    in_item.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [RegIdxW-1:0] idx, input logic [ApbDataW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  // upper data bits are junk, the block keeps only the register width
  task automatic program_regs(input logic [1:0] m, input logic [7:0] p8,
                              input logic [7:0] i8, input logic [15:0] p16,
                              input logic [15:0] i16);
    set_reg(REG_MODE, {30'($urandom()), m});
    set_reg(REG_POLY8, {24'($urandom()), p8});
    set_reg(REG_INIT8, {24'($urandom()), i8});
    set_reg(REG_POLY16, {16'($urandom()), p16});
    set_reg(REG_INIT16, {16'($urandom()), i16});
    set_reg(RegIdxW'($urandom_range(7, int'(REG_INIT16) + 1)), $urandom());
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_phase(input int ph);
    case (ph)
      0: program_regs(MODE_CRC8, POLY8_RST, INIT8_RST, POLY16_RST, INIT16_RST);
      1: program_regs(MODE_XMODEM, POLY8_RST, INIT8_RST, POLY16_RST, INIT16_RST);
      2: program_regs(MODE_KERMIT, POLY8_RST, INIT8_RST, POLY16_RST, 16'hFFFF);
      3: program_regs(MODE_ZERO, 8'($urandom()), 8'($urandom()), 16'($urandom()),
                      16'($urandom()));
      4: program_regs(MODE_CRC8, 8'hFF, 8'hFF, POLY16_RST, INIT16_RST);
      5: program_regs(MODE_XMODEM, POLY8_RST, INIT8_RST, 16'hFFFF, 16'hFFFF);
      6: program_regs(MODE_KERMIT, POLY8_RST, INIT8_RST, 16'h0000, 16'h0000);
      7: program_regs(MODE_CRC8, 8'h00, 8'h00, POLY16_RST, INIT16_RST);
      8: program_regs(MODE_XMODEM, 8'($urandom()), 8'($urandom()), 16'($urandom()),
                      16'($urandom()));
      9: program_regs(MODE_KERMIT, 8'($urandom()), 8'($urandom()), 16'($urandom()),
                      16'($urandom()));
      10: program_regs(MODE_CRC8, 8'($urandom()), 8'($urandom()), 16'($urandom()),
                       16'($urandom()));
      default: program_regs(2'($urandom()), 8'($urandom()), 8'($urandom()),
                            16'($urandom()), 16'($urandom()));
    endcase
  endtask

  task automatic run_directed();
    // reset defaults, crc8
    push_byte(8'hA5, 1'b0, 1'b1, 1'b0);
    push_byte(8'h00, 1'b1, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b1, 1'b1, 1'b1);
    push_byte(8'h31, 1'b1, 1'b0, 1'b0);
    push_byte(8'h32, 1'b0, 1'b0, 1'b1);
    push_byte(8'h33, 1'b0, 1'b1, 1'b0);
    drain_engine();
    program_regs(MODE_XMODEM, POLY8_RST, INIT8_RST, POLY16_RST, 16'hFFFF);
    push_byte(8'h31, 1'b1, 1'b0, 1'b1);
    push_byte(8'h32, 1'b0, 1'b0, 1'b1);
    push_byte(8'h33, 1'b0, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b1, 1'b1, 1'b1);
    push_byte(8'h00, 1'b1, 1'b1, 1'b0);
    drain_engine();
    program_regs(MODE_KERMIT, POLY8_RST, INIT8_RST, POLY16_RST, INIT16_RST);
    push_byte(8'h31, 1'b1, 1'b0, 1'b0);
    push_byte(8'h32, 1'b0, 1'b0, 1'b1);
    push_byte(8'h33, 1'b0, 1'b1, 1'b0);
    push_byte(8'h80, 1'b1, 1'b1, 1'b1);
    push_byte(8'h01, 1'b0, 1'b1, 1'b0);
    drain_engine();
    program_regs(MODE_ZERO, POLY8_RST, INIT8_RST, POLY16_RST, INIT16_RST);
    push_byte(8'h55, 1'b0, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b1, 1'b0, 1'b1);
    push_byte(8'h01, 1'b0, 1'b1, 1'b0);
    drain_engine();
  endtask

  task automatic stream_messages(input int n_items);
    int         sent;
    int         len;
    logic       odd;
    logic       cut;
    logic [7:0] b;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        push_byte(8'($urandom()), 1'($urandom()), 1'($urandom()), 1'($urandom()));
        sent++;
      end else begin
        len = ($urandom_range(15) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
        odd = ($urandom_range(7) == 0) ? ~len[0] : len[0];
        cut = ($urandom_range(15) == 0);
        for (int k = 0; k < len; k++) begin
          b = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 8'hFF : 8'h00)
                                       : 8'($urandom());
          push_byte(b, k == 0, (k == len - 1) && !cut, (k == 0) ? odd : 1'($urandom()));
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst_ni             <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_item.valid      <= 1'b0;
    in_item.data_byte  <= '0;
    in_item.first      <= 1'b0;
    in_item.last       <= 1'b0;
    in_item.odd_length <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    run_directed();
    for (int ph = 0; ph < NumPhases; ph++) begin
      load_phase(ph);
      case (ph % 4)
        0: begin
          send_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          send_pct  = 51;
          stall_pct = 0;
        end
        2: begin
          send_pct  = 0;
          stall_pct = 51;
        end
        default: begin
          send_pct  = 11;
          stall_pct = 11;
        end
      endcase
      stream_messages(ItemsPerPhase);
      drain_engine();
    end

    $display("run covered %0d bytes and %0d crc results over %0d register settings,",
             item_count, crc_count, NumPhases + 4);
    $display("crc8, xmodem, kermit and zero modes with sender gaps and receiver stalls");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
src/ccse_pkg.sv
src/ccse_if.sv
src/ccse_cfg.sv
src/ccse_step.sv
src/ccse_core.sv
src/crc8_crc16_stream_engine_unit.sv
verif/ccse_crc_checker.sv
verif/tb.sv
